// File: hdl/downscale_factor_select_unit_assert.svh
// Assertion macros shared by the downscale factor selector.
`ifndef DOWNSCALE_FACTOR_SELECT_UNIT_ASSERT_SVH
`define DOWNSCALE_FACTOR_SELECT_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("downscale factor select: check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("downscale factor select: check failed");

`endif

// File: hdl/dfs_pkg.sv
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int DIM_BITS       = 14;
    localparam int SHIFT_BITS     = 4;
    localparam int CODE_BITS      = 2;
    localparam int FORCE_BITS     = 3;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = DIM_BITS;
    localparam int FIT_BITS       = DIM_BITS + 3;
    localparam int NEAR_BITS      = DIM_BITS + 5;

    typedef logic [DIM_BITS-1:0]       dim_t;
    typedef logic [SHIFT_BITS-1:0]     shift_t;
    typedef logic [CODE_BITS-1:0]      code_t;
    typedef logic [FORCE_BITS-1:0]     force_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [FIT_BITS-1:0]       fit_t;
    typedef logic [NEAR_BITS-1:0]      near_t;

    localparam force_t FORCE_AUTO = 3'd0;
    localparam force_t FORCE_X1   = 3'd1;
    localparam force_t FORCE_X8   = 3'd4;

    localparam code_t CODE_X1 = 2'd0;
    localparam code_t CODE_X2 = 2'd1;
    localparam code_t CODE_X4 = 2'd2;
    localparam code_t CODE_X8 = 2'd3;

    localparam cfg_index_t CFG_CAN_DOWNSCALE    = 1'd0;
    localparam cfg_index_t CFG_MAX_TEXTURE_SIZE = 1'd1;

    localparam dim_t MAX_TEXTURE_SIZE_RESET = dim_t'(8192);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CAP
    } dfs_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cap_ctrl_t;

    typedef struct packed {
        logic   done;
        shift_t shift;
    } cap_sts_t;

endpackage

// File: hdl/downscale_factor_select_unit.sv
// Picks a power-of-two decimation shift for each frame request: the largest
// of x8, x4 or x2 that fits the view, else x1 (with hysteresis against
// shrinking the factor), or a forced factor, starting from x1 while
// downscaling is disabled; then raises it until the scaled source fits the
// texture limit, which may need 0 to 13 extra halvings at 14-bit sizes (a
// zero limit disables this cap). A request passes through a factor decision
// state, then a capping state that runs the shift-and-compare unit one
// halving step at a time, then goes back to idle. The result waits in an
// output register, so the next request can be taken before it is collected.
`timescale 1ns / 1ps
`include "downscale_factor_select_unit_assert.svh"

module downscale_factor_select_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dfs_pkg::dim_t          src_width,
    input  dfs_pkg::dim_t          src_height,
    input  dfs_pkg::dim_t          view_width,
    input  dfs_pkg::dim_t          view_height,
    input  logic                   pin_full_size,
    input  dfs_pkg::force_t        force_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dfs_pkg::shift_t        factor_shift,
    input  logic                   cfg_write_en,
    input  dfs_pkg::cfg_index_t    cfg_index,
    input  logic [dfs_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    dfs_pkg::dfs_state_t state_reg;
    dfs_pkg::dfs_state_t state_next;

    logic            can_downscale_reg;
    dfs_pkg::dim_t   max_texture_size_reg;

    dfs_pkg::dim_t   req_sw_reg;
    dfs_pkg::dim_t   req_sh_reg;
    dfs_pkg::dim_t   req_vw_reg;
    dfs_pkg::dim_t   req_vh_reg;
    logic            req_pin_reg;
    dfs_pkg::force_t req_force_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    dfs_pkg::shift_t factor_shift_reg;

    logic               accept;
    logic               commit;
    logic               out_load;
    dfs_pkg::code_t     code;
    dfs_pkg::shift_t    init_shift;
    dfs_pkg::cap_ctrl_t cap_ctrl;
    dfs_pkg::cap_sts_t  cap_sts;

    assign in_ready     = (state_reg == dfs_pkg::ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign factor_shift = factor_shift_reg;
    assign init_shift   = can_downscale_reg
        ? {{(dfs_pkg::SHIFT_BITS - dfs_pkg::CODE_BITS){1'b0}}, code} : '0;

    dfs_decide u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (commit),
        .src_width     (req_sw_reg),
        .src_height    (req_sh_reg),
        .view_width    (req_vw_reg),
        .view_height   (req_vh_reg),
        .pin_full_size (req_pin_reg),
        .force_code    (req_force_reg),
        .code          (code)
    );

    dfs_cap u_cap (
        .clk              (clk),
        .ctrl             (cap_ctrl),
        .max_texture_size (max_texture_size_reg),
        .src_width        (req_sw_reg),
        .src_height       (req_sh_reg),
        .init_shift       (init_shift),
        .sts              (cap_sts)
    );

    always_comb
    begin
        state_next    = state_reg;
        commit        = 1'b0;
        out_load      = 1'b0;
        cap_ctrl.load = 1'b0;
        cap_ctrl.step = 1'b0;
        case (state_reg)
            dfs_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = dfs_pkg::ST_DECIDE;
            end
            dfs_pkg::ST_DECIDE:
            begin
                commit        = 1'b1;
                cap_ctrl.load = 1'b1;
                state_next    = dfs_pkg::ST_CAP;
            end
            dfs_pkg::ST_CAP:
            begin
                if (!cap_sts.done)
                    cap_ctrl.step = 1'b1;
                else if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = dfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dfs_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= dfs_pkg::ST_IDLE;
            out_valid_reg        <= 1'b0;
            can_downscale_reg    <= 1'b1;
            max_texture_size_reg <= dfs_pkg::MAX_TEXTURE_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    dfs_pkg::CFG_CAN_DOWNSCALE:    can_downscale_reg    <= cfg_wdata[0];
                    dfs_pkg::CFG_MAX_TEXTURE_SIZE: max_texture_size_reg <= cfg_wdata;
                    default:                       can_downscale_reg    <= can_downscale_reg;
                endcase
            end
        end
    end

    // Hold the request for the whole computation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_sw_reg    <= src_width;
            req_sh_reg    <= src_height;
            req_vw_reg    <= view_width;
            req_vh_reg    <= view_height;
            req_pin_reg   <= pin_full_size;
            req_force_reg <= force_code;
        end
        if (out_load)
            factor_shift_reg <= cap_sts.shift;
    end

    `DFS_ASSERT_NEXT(a_accept_decides, accept, state_reg == dfs_pkg::ST_DECIDE)
    `DFS_ASSERT_NEXT(a_decide_caps, state_reg == dfs_pkg::ST_DECIDE, state_reg == dfs_pkg::ST_CAP)
    `DFS_ASSERT_NEXT(a_cap_steps, cap_ctrl.step, cap_sts.shift == $past(cap_sts.shift) + 1'b1)
    `DFS_ASSERT_NEXT(a_finish_loads, out_load, out_valid_reg && state_reg == dfs_pkg::ST_IDLE)
    `DFS_ASSERT_SAME(a_busy_not_ready, state_reg != dfs_pkg::ST_IDLE, !accept)

endmodule

// File: hdl/dfs_decide.sv
`timescale 1ns / 1ps

module dfs_decide (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  dfs_pkg::dim_t   src_width,
    input  dfs_pkg::dim_t   src_height,
    input  dfs_pkg::dim_t   view_width,
    input  dfs_pkg::dim_t   view_height,
    input  logic            pin_full_size,
    input  dfs_pkg::force_t force_code,
    output dfs_pkg::code_t  code
);

    dfs_pkg::code_t  held_code_reg;
    dfs_pkg::dim_t   last_sw_reg;
    dfs_pkg::dim_t   last_sh_reg;
    dfs_pkg::dim_t   held_vw_reg;
    dfs_pkg::dim_t   held_vh_reg;

    dfs_pkg::force_t force_eff;
    dfs_pkg::force_t force_m1;
    dfs_pkg::dim_t   vw_eff;
    dfs_pkg::dim_t   vh_eff;
    dfs_pkg::dim_t   diff_w;
    dfs_pkg::dim_t   diff_h;
    dfs_pkg::fit_t   sw_x;
    dfs_pkg::fit_t   sh_x;
    dfs_pkg::fit_t   vw_x;
    dfs_pkg::fit_t   vh_x;
    dfs_pkg::near_t  diff_w_x;
    dfs_pkg::near_t  diff_h_x;
    logic            fit8;
    logic            fit4;
    logic            fit2;
    logic            near_w;
    logic            near_h;
    logic            hold;
    dfs_pkg::code_t  fit_code;
    dfs_pkg::code_t  auto_code;

    always_comb
    begin
        force_eff = pin_full_size ? dfs_pkg::FORCE_X1 : force_code;
        force_m1  = force_eff - dfs_pkg::FORCE_X1;

        // Fall back to the source size while the view is unknown
        if (view_width == '0 || view_height == '0)
        begin
            vw_eff = src_width;
            vh_eff = src_height;
        end
        else
        begin
            vw_eff = view_width;
            vh_eff = view_height;
        end

        sw_x = dfs_pkg::fit_t'(src_width);
        sh_x = dfs_pkg::fit_t'(src_height);
        vw_x = dfs_pkg::fit_t'(vw_eff);
        vh_x = dfs_pkg::fit_t'(vh_eff);
        fit8 = ((vw_x << 3) <= sw_x) && ((vh_x << 3) <= sh_x);
        fit4 = ((vw_x << 2) <= sw_x) && ((vh_x << 2) <= sh_x);
        fit2 = ((vw_x << 1) <= sw_x) && ((vh_x << 1) <= sh_x);
        if (fit8)
            fit_code = dfs_pkg::CODE_X8;
        else if (fit4)
            fit_code = dfs_pkg::CODE_X4;
        else if (fit2)
            fit_code = dfs_pkg::CODE_X2;
        else
            fit_code = dfs_pkg::CODE_X1;

        diff_w   = (vw_eff >= held_vw_reg) ? vw_eff - held_vw_reg : held_vw_reg - vw_eff;
        diff_h   = (vh_eff >= held_vh_reg) ? vh_eff - held_vh_reg : held_vh_reg - vh_eff;
        diff_w_x = dfs_pkg::near_t'(diff_w);
        diff_h_x = dfs_pkg::near_t'(diff_h);
        near_w   = ((diff_w_x << 4) + (diff_w_x << 2)) < dfs_pkg::near_t'(vw_eff);
        near_h   = ((diff_h_x << 4) + (diff_h_x << 2)) < dfs_pkg::near_t'(vh_eff);

        // Hold a smaller factor back while the source stays put and the view stays near the held size
        hold = (fit_code < held_code_reg) && (last_sw_reg == src_width)
            && (last_sh_reg == src_height) && near_w && near_h;
        auto_code = hold ? held_code_reg : fit_code;

        if (force_eff == dfs_pkg::FORCE_AUTO)
            code = auto_code;
        else if (force_eff >= dfs_pkg::FORCE_X8)
            code = dfs_pkg::CODE_X8;
        else
            code = force_m1[dfs_pkg::CODE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_code_reg <= dfs_pkg::CODE_X1;
            last_sw_reg   <= '0;
            last_sh_reg   <= '0;
            held_vw_reg   <= '0;
            held_vh_reg   <= '0;
        end
        else if (commit && force_eff == dfs_pkg::FORCE_AUTO)
        begin
            last_sw_reg <= src_width;
            last_sh_reg <= src_height;
            if (auto_code != held_code_reg)
            begin
                held_code_reg <= auto_code;
                held_vw_reg   <= vw_eff;
                held_vh_reg   <= vh_eff;
            end
        end
    end

endmodule

// File: hdl/dfs_cap.sv
`timescale 1ns / 1ps

module dfs_cap (
    input  logic               clk,
    input  dfs_pkg::cap_ctrl_t ctrl,
    input  dfs_pkg::dim_t      max_texture_size,
    input  dfs_pkg::dim_t      src_width,
    input  dfs_pkg::dim_t      src_height,
    input  dfs_pkg::shift_t    init_shift,
    output dfs_pkg::cap_sts_t  sts
);

    dfs_pkg::dim_t   nw_reg;
    dfs_pkg::dim_t   nh_reg;
    dfs_pkg::shift_t shift_reg;

    always_comb
    begin
        sts.done  = (max_texture_size == '0)
            || ((nw_reg <= max_texture_size) && (nh_reg <= max_texture_size));
        sts.shift = shift_reg;
    end

    // Halve both dimensions once per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            nw_reg    <= src_width >> init_shift;
            nh_reg    <= src_height >> init_shift;
            shift_reg <= init_shift;
        end
        else if (ctrl.step)
        begin
            nw_reg    <= nw_reg >> 1;
            nh_reg    <= nh_reg >> 1;
            shift_reg <= shift_reg + 1'b1;
        end
    end

endmodule
